// File: rtl/lkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkr_pkg
// shared types and codes for the keyed recency registry
// ----------------------------------------------------------------------------
package lkr_pkg;

  localparam int unsigned FIELD_W = 21;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_EVICT  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // byte address of the capacity register
  localparam logic [1:0] REG_CAPACITY = 2'd0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] key_x;
    logic [FIELD_W-1:0] key_y;
    logic [FIELD_W-1:0] key_z;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               overflow;
    logic               removed_valid;
    logic [FIELD_W-1:0] removed_x;
    logic [FIELD_W-1:0] removed_y;
    logic [FIELD_W-1:0] removed_z;
    logic [CNT_W-1:0]   removed_total;
    logic [CNT_W-1:0]   entries_now;
    logic               last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch request
    logic search;   // compare key against table
    logic apply;    // insert or touch update
    logic find_old; // locate least recent slot
    logic remove;   // drop located slot
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_access;
    logic need_remove;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/lkr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkr_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface lkr_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lkr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkr_datapath
// key table, recency ranks, count and result formatting
// ----------------------------------------------------------------------------
module lkr_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COORD_BITS    = 21
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lkr_pkg::req_t   req,
  input  wire lkr_pkg::dp_cmd_t cmd,
  input  wire logic [6:0]      capacity,
  output lkr_pkg::dp_sts_t     sts,
  output lkr_pkg::rsp_t        rsp
);
  import lkr_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned KW = 3 * COORD_BITS;

  logic [KW-1:0]    key_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IW-1:0]    rank_r [TABLE_ENTRIES];
  logic [CNT_W-1:0] count_r;
  req_t             req_r;
  logic             hit_r;
  logic [IW-1:0]    hit_idx_r;
  logic [IW-1:0]    free_idx_r;
  logic             free_ok_r;
  logic [IW-1:0]    old_idx_r;
  logic [CNT_W-1:0] total_r;
  logic [KW-1:0]    rd_key_r;

  logic [KW-1:0]    key_w;
  logic [TABLE_ENTRIES-1:0] match_w;
  logic             hit_w;
  logic [IW-1:0]    hit_idx_w;
  logic             free_ok_w;
  logic [IW-1:0]    free_idx_w;
  logic [IW-1:0]    old_idx_w;
  logic [CNT_W-1:0] limit_w;
  logic [CNT_W-1:0] entries_w;

  assign key_w = {req_r.key_x[COORD_BITS-1:0], req_r.key_y[COORD_BITS-1:0],
                  req_r.key_z[COORD_BITS-1:0]};

  always_comb begin
    hit_w = 1'b0; hit_idx_w = '0; free_ok_w = 1'b0; free_idx_w = '0; old_idx_w = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      match_w[i] = valid_r[i] && (key_mem[i] == key_w);
      if (match_w[i]) begin
        hit_w = 1'b1; hit_idx_w = IW'(i);
      end
      if (!valid_r[i]) begin
        free_ok_w = 1'b1; free_idx_w = IW'(i);
      end
      if (valid_r[i] && ({1'b0, rank_r[i]} == (IW+1)'(count_r - 1'b1))) old_idx_w = IW'(i);
    end
  end

  assign limit_w = (req_r.kind == KIND_CLEAR) ? '0 :
                   (capacity == '0) ? CNT_W'(1) : capacity;
  assign sts.is_access   = (req_r.kind == KIND_INSERT) || (req_r.kind == KIND_LOOKUP);
  assign sts.need_remove = count_r > limit_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      total_r <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      if (cmd.load) total_r <= '0;
      if (cmd.apply && req_r.kind == KIND_INSERT) begin
        if (hit_r) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (valid_r[i] && rank_r[i] < rank_r[hit_idx_r]) rank_r[i] <= rank_r[i] + 1'b1;
          rank_r[hit_idx_r] <= '0;
        end else if (count_r < CNT_W'(TABLE_ENTRIES) && free_ok_r) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
          rank_r[free_idx_r] <= '0;
          valid_r[free_idx_r] <= 1'b1;
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.remove) begin
        valid_r[old_idx_r] <= 1'b0;
        rank_r[old_idx_r]  <= '0;
        count_r <= count_r - 1'b1;
        total_r <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
    if (cmd.search) begin
      hit_r <= hit_w; hit_idx_r <= hit_idx_w;
      free_ok_r <= free_ok_w; free_idx_r <= free_idx_w;
    end
    if (cmd.apply && req_r.kind == KIND_INSERT && !hit_r && free_ok_r &&
        count_r < CNT_W'(TABLE_ENTRIES))
      key_mem[free_idx_r] <= key_w;
    if (cmd.find_old) begin
      old_idx_r <= old_idx_w;
      rd_key_r  <= key_mem[old_idx_w];
    end
  end

  // response, valid in the cycle of apply or remove
  assign entries_w = cmd.remove ? count_r - 1'b1 :
                     (req_r.kind == KIND_INSERT && !hit_r && count_r < CNT_W'(TABLE_ENTRIES))
                     ? count_r + 1'b1 : count_r;

  always_comb begin
    rsp = '0;
    rsp.entries_now = entries_w;
    if (cmd.remove) begin
      rsp.removed_valid = 1'b1;
      rsp.removed_x = FIELD_W'(signed'(rd_key_r[KW-1 -: COORD_BITS]));
      rsp.removed_y = FIELD_W'(signed'(rd_key_r[2*COORD_BITS-1 -: COORD_BITS]));
      rsp.removed_z = FIELD_W'(signed'(rd_key_r[COORD_BITS-1:0]));
      rsp.removed_total = total_r + 1'b1;
      rsp.last = !(count_r - 1'b1 > limit_w);
    end else if (sts.is_access) begin
      rsp.hit = hit_r;
      rsp.overflow = req_r.kind == KIND_INSERT && !hit_r &&
                     count_r >= CNT_W'(TABLE_ENTRIES);
      rsp.last = 1'b1;
    end else begin
      rsp.last = 1'b1;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES)) else $error("count above table size");
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r)) else $error("count and valid bits disagree");
  a_remove_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> valid_r[old_idx_r]) else $error("removing empty slot");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_w)) else $error("duplicate key");

endmodule
`default_nettype wire

// File: rtl/lkr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkr_ctrl
// sequencer: search/apply for access requests, find/remove loop for drains
// ----------------------------------------------------------------------------
module lkr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lkr_pkg::rsp_t     rsp_in,
  output lkr_pkg::rsp_t          out_data,
  input  wire lkr_pkg::dp_sts_t  sts,
  output lkr_pkg::dp_cmd_t       cmd
);
  import lkr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_APPLY, S_FIND, S_REMOVE, S_OUT} state_t;
  state_t state_r;
  logic   done_r;
  rsp_t   rsp_r;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_data  = rsp_r;

  always_comb begin
    cmd = '0;
    cmd.load     = in_valid && in_ready;
    cmd.search   = state_r == S_SEARCH;
    cmd.apply    = state_r == S_APPLY;
    cmd.find_old = state_r == S_FIND;
    cmd.remove   = state_r == S_REMOVE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_SEARCH;
        S_SEARCH: state_r <= sts.is_access ? S_APPLY : (sts.need_remove ? S_FIND : S_APPLY);
        S_APPLY: begin
          rsp_r <= rsp_in; done_r <= 1'b1; state_r <= S_OUT;
        end
        S_FIND:   state_r <= S_REMOVE;
        S_REMOVE: begin
          rsp_r <= rsp_in; done_r <= rsp_in.last; state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= done_r ? S_IDLE : S_FIND;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cmd.load) else $error("accept while busy");
  a_remove_follows_find: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> $past(cmd.find_old)) else $error("remove without find");

endmodule
`default_nettype wire

// File: rtl/lru_keyed_registry_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_keyed_registry_unit
// recency-ordered voxel key table with insert, lookup, evict and clear
// ----------------------------------------------------------------------------
// channel  dir  contents
// in_*     in   kind, key_x, key_y, key_z
// out_*    out  hit, overflow, removed key, totals, last
// cfg_*    in   apb register 0 = capacity
// insert or lookup: accept, search, apply, output; a new request is taken only when idle
// evict or clear: accept and search, then for each removed key find oldest and read key,
// remove, output; with nothing to remove, apply and output instead
// reset clears the valid bits and count at once, no clearing pass
// a stalled result holds the sequencer in its output state
// ----------------------------------------------------------------------------
module lru_keyed_registry_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COORD_BITS    = 21
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lkr_if.sink              in_ch,
  lkr_if.source            out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import lkr_pkg::*;

  logic [6:0] capacity_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  rsp_t       rsp;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CAPACITY) ? {25'd0, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[6:0];
    end
  end

  lkr_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .rsp_in(rsp), .out_data(out_ch.data), .sts, .cmd
  );

  lkr_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst_n, .req(in_ch.data), .cmd, .capacity(capacity_r), .sts, .rsp
  );

endmodule
`default_nettype wire
